// File: rtl/kcc_pkg.sv
// shared constants and codes for the k-core collapse engine
package kcc_pkg;

  localparam int unsigned MAX_NODES_DEF   = 4096;
  localparam int unsigned MAX_ENTRIES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 8192;

  localparam int unsigned NODE_W   = 12;
  localparam int unsigned CORE_W   = 16;
  localparam int unsigned NCOUNT_W = 13;

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_ADD   = 3'd1;
  localparam logic [2:0] FUNC_BEGIN = 3'd2;
  localparam logic [2:0] FUNC_SEED  = 3'd3;
  localparam logic [2:0] FUNC_POP   = 3'd4;

  localparam logic [1:0] ST_ACCEPT  = 2'd0;
  localparam logic [1:0] ST_REMOVED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam logic CFG_CORE_ORDER = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

endpackage

// File: rtl/k_core_collapse_cascade_top.sv
// k-core collapse engine: sequencer over degree, list and queue memories
// clear and begin sweep the node rows, one memory row per cycle; add reads, then writes the
//   loaded degree; seed, reject and empty pop finish at dispatch; pop reads the queue head,
//   list start and length, then per neighbor entry a read-modify-write of one working degree
// one item at a time; busy is high from acceptance until the done_o cycle
// after reset a clearing pass over all MAX_NODES rows runs with busy high, no result
// results appear on done_o for one cycle; the receiver cannot stall
module k_core_collapse_cascade_top #(
  parameter int unsigned MAX_NODES   = kcc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_ENTRIES = kcc_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned QUEUE_DEPTH = kcc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  func_i,
  input  logic [kcc_pkg::NODE_W-1:0]  node_i,
  input  logic [kcc_pkg::NODE_W-1:0]  neighbor_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [kcc_pkg::NODE_W-1:0]  removed_node_o,
  output logic                        queue_empty_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [kcc_pkg::CORE_W-1:0]  cfg_data_i
);

  localparam int unsigned NAW = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = $clog2(MAX_ENTRIES);
  localparam int unsigned DW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW  = kcc_pkg::NODE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CLEAR, S_COPY, S_ADD_RD, S_ADD_WR,
    S_POP_RD, S_POP_ID, S_POP_LD, S_POP_LEN,
    S_WALK_NB, S_WALK_U, S_WALK_RD, S_WALK_UPD
  } state_e;

  state_e state_q, state_d;

  logic [kcc_pkg::CORE_W-1:0]   core_q;
  logic [kcc_pkg::NCOUNT_W-1:0] ncount_q;

  logic [2:0]    func_q;
  logic [NW-1:0] node_q, nbr_q, v_q, v_d, u_q, u_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rep_q, rep_d;
  logic [DW-1:0] fill_q, fill_d, pos_q, pos_d, cnt_q, cnt_d;
  logic [NW-1:0] last_q, last_d;
  logic [QAW-1:0] head_q, head_d, tail_q, tail_d;
  logic [QCW-1:0] count_q, count_d;

  logic          done_q, done_d, qempty_q, qempty_d;
  logic [1:0]    status_q, status_d;
  logic [NW-1:0] removed_q, removed_d;

  // memory ports
  logic           ld_we, wd_we, ls_we, ns_we, q_we;
  logic [NAW-1:0] ld_wa, ld_ra, wd_wa, ls_wa;
  logic [DW-1:0]  ld_wd, ld_rd, wd_wd, wd_rd;
  logic [EAW-1:0] ls_wd, ls_rd, ns_wa;
  logic [NW-1:0]  ns_rd, q_rd;
  logic [QAW-1:0] q_wa;
  logic [NW-1:0]  q_wd_sel;

  logic [31:0]    lim, node32, nbr32, v32, u32;
  logic [NAW-1:0] node_a, v_a, u_a;
  logic [CW-1:0]  idx_m1;
  logic           node_ok, nbr_ok, q_room;

  assign lim    = (32'(ncount_q) < MAX_NODES) ? 32'(ncount_q) : MAX_NODES;
  assign node32 = 32'(node_q);
  assign nbr32  = 32'(nbr_q);
  assign v32    = 32'(v_q);
  assign u32    = 32'(u_q);
  assign node_a = node32[NAW-1:0];
  assign v_a    = v32[NAW-1:0];
  assign u_a    = u32[NAW-1:0];
  assign idx_m1 = idx_q - 1'b1;
  assign node_ok = node32 < lim;
  assign nbr_ok  = nbr32 < lim;
  assign q_room  = 32'(count_q) < QUEUE_DEPTH;

  assign ld_ra = (state_q == S_COPY) ? idx_q[NAW-1:0] :
                 (state_q == S_ADD_RD) ? node_a : v_a;

  assign q_wd_sel = (state_q == S_WALK_UPD) ? u_q : node_q;

  kcc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_loaded (
    .clk_i(clk_i), .we_i(ld_we), .wa_i(ld_wa), .wd_i(ld_wd), .ra_i(ld_ra), .rd_o(ld_rd)
  );
  kcc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_working (
    .clk_i(clk_i), .we_i(wd_we), .wa_i(wd_wa), .wd_i(wd_wd), .ra_i(u_a), .rd_o(wd_rd)
  );
  kcc_ram #(.WIDTH(EAW), .DEPTH(MAX_NODES)) u_start (
    .clk_i(clk_i), .we_i(ls_we), .wa_i(ls_wa), .wd_i(ls_wd), .ra_i(v_a), .rd_o(ls_rd)
  );
  kcc_ram #(.WIDTH(NW), .DEPTH(MAX_ENTRIES)) u_nbr (
    .clk_i(clk_i), .we_i(ns_we), .wa_i(ns_wa), .wd_i(nbr_q),
    .ra_i(pos_q[EAW-1:0]), .rd_o(ns_rd)
  );
  kcc_ram #(.WIDTH(NW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i(clk_i), .we_i(q_we), .wa_i(q_wa), .wd_i(q_wd_sel), .ra_i(head_q), .rd_o(q_rd)
  );

  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    u_d       = u_q;
    idx_d     = idx_q;
    rep_d     = rep_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    removed_d = removed_q;
    ld_we = 1'b0; ld_wa = node_a; ld_wd = '0;
    wd_we = 1'b0; wd_wa = node_a; wd_wd = '0;
    ls_we = 1'b0; ls_wa = node_a; ls_wd = fill_q[EAW-1:0];
    ns_we = 1'b0; ns_wa = fill_q[EAW-1:0];
    q_we  = 1'b0; q_wa  = tail_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d   = S_IDLE;
        done_d    = 1'b1;
        removed_d = '0;
        status_d  = kcc_pkg::ST_REJECT;
        case (func_q)
          kcc_pkg::FUNC_CLEAR: begin
            done_d  = 1'b0;
            fill_d  = '0;
            last_d  = '0;
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
            idx_d   = '0;
            rep_d   = 1'b1;
            state_d = S_CLEAR;
          end
          kcc_pkg::FUNC_ADD: begin
            if (node_ok && nbr_ok && node_q >= last_q && 32'(fill_q) < MAX_ENTRIES) begin
              done_d  = 1'b0;
              state_d = S_ADD_RD;
            end
          end
          kcc_pkg::FUNC_BEGIN: begin
            done_d  = 1'b0;
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
            idx_d   = '0;
            state_d = S_COPY;
          end
          kcc_pkg::FUNC_SEED: begin
            if (node_ok && q_room) begin
              q_we     = 1'b1;
              wd_we    = 1'b1;
              tail_d   = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              count_d  = count_q + 1'b1;
              status_d = kcc_pkg::ST_ACCEPT;
            end
          end
          kcc_pkg::FUNC_POP: begin
            if (count_q == '0) begin
              status_d = kcc_pkg::ST_EMPTY;
            end else begin
              done_d  = 1'b0;
              state_d = S_POP_RD;
            end
          end
          default: begin
            status_d = kcc_pkg::ST_REJECT;
          end
        endcase
      end
      S_CLEAR: begin
        ld_we = 1'b1; ld_wa = idx_q[NAW-1:0];
        wd_we = 1'b1; wd_wa = idx_q[NAW-1:0];
        idx_d = idx_q + 1'b1;
        if (idx_q == CW'(MAX_NODES - 1)) begin
          state_d = S_IDLE;
          if (rep_q) begin
            done_d    = 1'b1;
            status_d  = kcc_pkg::ST_ACCEPT;
            removed_d = '0;
          end
        end
      end
      S_COPY: begin
        // read row idx while writing row idx-1 from the previous read
        if (idx_q != '0) begin
          wd_we = 1'b1;
          wd_wa = idx_m1[NAW-1:0];
          wd_wd = ld_rd;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == CW'(MAX_NODES)) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = kcc_pkg::ST_ACCEPT;
          removed_d = '0;
        end
      end
      S_ADD_RD: begin
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        ls_we  = (ld_rd == '0);
        ns_we  = 1'b1;
        ld_we  = 1'b1;
        ld_wd  = ld_rd + 1'b1;
        fill_d = fill_q + 1'b1;
        last_d = node_q;
        state_d   = S_IDLE;
        done_d    = 1'b1;
        status_d  = kcc_pkg::ST_ACCEPT;
        removed_d = '0;
      end
      S_POP_RD: begin
        state_d = S_POP_ID;
      end
      S_POP_ID: begin
        v_d     = q_rd;
        head_d  = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
        state_d = S_POP_LD;
      end
      S_POP_LD: begin
        state_d = S_POP_LEN;
      end
      S_POP_LEN: begin
        pos_d = DW'(ls_rd);
        cnt_d = ld_rd;
        if (ld_rd == '0) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = kcc_pkg::ST_REMOVED;
          removed_d = v_q;
        end else begin
          state_d = S_WALK_NB;
        end
      end
      S_WALK_NB: begin
        state_d = S_WALK_U;
      end
      S_WALK_U: begin
        u_d     = ns_rd;
        state_d = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_d = S_WALK_UPD;
      end
      S_WALK_UPD: begin
        // decrement held at zero, queue on the drop from k to k-1 if the queue has room
        if (wd_rd != '0) begin
          wd_we = 1'b1;
          wd_wa = u_a;
          wd_wd = wd_rd - 1'b1;
          if (32'(wd_rd) == 32'(core_q) && q_room) begin
            q_we    = 1'b1;
            tail_d  = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        pos_d = pos_q + 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DW'(1)) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = kcc_pkg::ST_REMOVED;
          removed_d = v_q;
        end else begin
          state_d = S_WALK_NB;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    qempty_d = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      core_q    <= kcc_pkg::CORE_W'(2);
      ncount_q  <= kcc_pkg::NCOUNT_W'(4096);
      idx_q     <= '0;
      rep_q     <= 1'b0;
      fill_q    <= '0;
      last_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      status_q  <= '0;
      removed_q <= '0;
      qempty_q  <= 1'b1;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rep_q     <= rep_d;
      fill_q    <= fill_d;
      last_q    <= last_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      done_q    <= done_d;
      status_q  <= status_d;
      removed_q <= removed_d;
      qempty_q  <= qempty_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == kcc_pkg::CFG_CORE_ORDER) begin
          core_q <= cfg_data_i;
        end else begin
          ncount_q <= cfg_data_i[kcc_pkg::NCOUNT_W-1:0];
        end
      end
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      func_q <= func_i;
      node_q <= node_i;
      nbr_q  <= neighbor_i;
    end
    v_q   <= v_d;
    u_q   <= u_d;
    pos_q <= pos_d;
    cnt_q <= cnt_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign removed_node_o = removed_q;
  assign queue_empty_o  = qempty_q;

endmodule

// File: rtl/kcc_ram.sv
// generic single-write, single-read ram with registered read
module kcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  input  logic [$clog2(DEPTH)-1:0] ra_i,
  output logic [WIDTH-1:0]         rd_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd_q <= mem_q[ra_i];
  end

  assign rd_o = rd_q;

endmodule

// File: tb/sv/tb_k_core_collapse_cascade_top.sv
// self-checking testbench for the k-core collapse engine
`timescale 1ns / 1ps

module tb_k_core_collapse_cascade_top;

  localparam int unsigned NNODES   = kcc_pkg::MAX_NODES_DEF;
  localparam int unsigned NENTRIES = kcc_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned QDEPTH   = kcc_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned NW       = kcc_pkg::NODE_W;
  localparam logic [2:0] FUNC_UNDEF_LO  = 3'd5;
  localparam logic [2:0] FUNC_UNDEF_MID = 3'd6;
  localparam logic [2:0] FUNC_UNDEF_HI  = 3'd7;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned RAND_ITEMS  = 430;

  typedef struct packed {
    logic [1:0]    status;
    logic [NW-1:0] removed;
    logic          qempty;
  } result_t;

  typedef struct packed {
    logic [2:0]    f;
    logic [NW-1:0] n;
    logic [NW-1:0] b;
    bit            typed;
    result_t       res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func_i = kcc_pkg::FUNC_CLEAR;
  logic [NW-1:0] node_i = '0;
  logic [NW-1:0] neighbor_i = '0;
  logic done_o;
  logic [1:0] status_o;
  logic [NW-1:0] removed_node_o;
  logic queue_empty_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = kcc_pkg::CFG_CORE_ORDER;
  logic [kcc_pkg::CORE_W-1:0] cfg_data_i = '0;

  k_core_collapse_cascade_top dut (.*);

  always #10 clk_i = ~clk_i;

  // engine mirror
  logic [kcc_pkg::CORE_W-1:0]   k_order;
  logic [kcc_pkg::NCOUNT_W-1:0] n_count;
  logic [16:0]   lst_start [NNODES];
  logic [16:0]   deg_loaded [NNODES];
  logic [16:0]   deg_work [NNODES];
  logic [NW-1:0] adj_store [NENTRIES];
  logic [NW-1:0] rm_queue [QDEPTH];
  int unsigned   fill_cnt, owner_last, qh, qt, qn;

  result_t pending_results[$];
  row_t rows[$];
  int unsigned errors, removals, rejects, rand_sent;
  int unsigned stall_cnt = 0;
  bit gaps_on, count_rand;
  int burst_left;

  function automatic int unsigned node_lim();
    return (32'(n_count) < NNODES) ? 32'(n_count) : NNODES;
  endfunction

  function automatic bit queue_in(int unsigned v);
    if (qn >= QDEPTH) return 1'b0;
    rm_queue[qt] = v[NW-1:0];
    qt = (qt + 1 >= QDEPTH) ? 0 : qt + 1;
    qn++;
    return 1'b1;
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < NNODES; i++) begin
      lst_start[i] = '0;
      deg_loaded[i] = '0;
      deg_work[i] = '0;
    end
    fill_cnt = 0;
    owner_last = 0;
    qh = 0; qt = 0; qn = 0;
  endfunction

  function automatic void add_row(logic [2:0] f, int unsigned n, int unsigned b,
                                  bit typed, result_t res);
    row_t r;
    r.f = f;
    r.n = n[NW-1:0];
    r.b = b[NW-1:0];
    r.typed = typed;
    r.res = res;
    rows = {rows, r};
  endfunction

  function automatic result_t peel_step(logic [2:0] f, int unsigned n, int unsigned b);
    result_t r;
    int unsigned lim, v, pos, stop, u;
    logic [16:0] old;
    lim = node_lim();
    r = '{status: kcc_pkg::ST_REJECT, removed: '0, qempty: 1'b0};
    case (f)
      kcc_pkg::FUNC_CLEAR: begin
        wipe_graph();
        r.status = kcc_pkg::ST_ACCEPT;
      end
      kcc_pkg::FUNC_ADD: begin
        if (n < lim && b < lim && n >= owner_last && fill_cnt < NENTRIES) begin
          if (deg_loaded[n] == '0) lst_start[n] = 17'(fill_cnt);
          adj_store[fill_cnt] = b[NW-1:0];
          fill_cnt++;
          deg_loaded[n] = deg_loaded[n] + 17'd1;
          owner_last = n;
          r.status = kcc_pkg::ST_ACCEPT;
        end
      end
      kcc_pkg::FUNC_BEGIN: begin
        for (int i = 0; i < NNODES; i++) deg_work[i] = deg_loaded[i];
        qh = 0; qt = 0; qn = 0;
        r.status = kcc_pkg::ST_ACCEPT;
      end
      kcc_pkg::FUNC_SEED: begin
        if (n < lim && queue_in(n)) begin
          deg_work[n] = '0;
          r.status = kcc_pkg::ST_ACCEPT;
        end
      end
      kcc_pkg::FUNC_POP: begin
        if (qn == 0) begin
          r.status = kcc_pkg::ST_EMPTY;
        end else begin
          v = 32'(rm_queue[qh]);
          qh = (qh + 1 >= QDEPTH) ? 0 : qh + 1;
          qn--;
          r.status = kcc_pkg::ST_REMOVED;
          r.removed = v[NW-1:0];
          pos = 32'(lst_start[v]);
          stop = pos + 32'(deg_loaded[v]);
          for (; pos < stop && pos < NENTRIES; pos++) begin
            u = 32'(adj_store[pos]);
            old = deg_work[u];
            if (old != '0) begin
              deg_work[u] = old - 17'd1;
              if (32'(old) == 32'(k_order)) void'(queue_in(u));
            end
          end
        end
      end
      default: ;
    endcase
    r.qempty = (qn == 0);
    return r;
  endfunction

  task automatic send_word(logic [2:0] f, int unsigned n, int unsigned b,
                           bit typed = 0, result_t want = '0);
    result_t r;
    result_t exp_r;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    r = peel_step(f, n, b);
    exp_r = typed ? want : r;
    pending_results = {pending_results, exp_r};
    if (count_rand) rand_sent++;
    start = 1'b1;
    func_i = f;
    node_i = n[NW-1:0];
    neighbor_i = b[NW-1:0];
    @(negedge clk_i);
    start = 1'b0;
    if (gaps_on) begin
      if (burst_left <= 0) begin
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        burst_left = $urandom_range(0, 14);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk_i);
    while (busy || pending_results.size() != 0) @(negedge clk_i);
    if (idx == kcc_pkg::CFG_CORE_ORDER) k_order = val[kcc_pkg::CORE_W-1:0];
    else n_count = val[kcc_pkg::NCOUNT_W-1:0];
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[kcc_pkg::CORE_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (removed_node_o !== e.removed) begin
          $error("removed_node: expected %0d, got %0d", e.removed, removed_node_o);
          errors++;
        end
        if (queue_empty_o !== e.qempty) begin
          $error("queue_empty: expected %0d, got %0d", e.qempty, queue_empty_o);
          errors++;
        end
        if (e.status == kcc_pkg::ST_REMOVED) removals++;
        if (e.status == kcc_pkg::ST_REJECT) rejects++;
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if (start && !busy) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL k_core_collapse_cascade_top");
      $finish;
    end
  end

  initial begin
    int unsigned lim, g, base, nb, nd, pops;
    int unsigned core_opts[6];
    int unsigned cnt_opts[6];
    core_opts = '{1, 2, 3, 4, 65535, 2};
    cnt_opts  = '{1, 2, 4096, 4095, 30, 4096};
    errors = 0; removals = 0; rejects = 0; rand_sent = 0;
    gaps_on = 1; count_rand = 0; burst_left = 0;
    k_order = 2;
    n_count = 4096;
    wipe_graph();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows
    add_row(kcc_pkg::FUNC_POP, 0, 0, 1, '{kcc_pkg::ST_EMPTY, 0, 1});
    add_row(FUNC_UNDEF_LO, 7, 9, 1, '{kcc_pkg::ST_REJECT, 0, 1});
    add_row(FUNC_UNDEF_MID, 0, 0, 1, '{kcc_pkg::ST_REJECT, 0, 1});
    add_row(FUNC_UNDEF_HI, 4095, 4095, 1, '{kcc_pkg::ST_REJECT, 0, 1});
    add_row(kcc_pkg::FUNC_SEED, 4095, 0, 1, '{kcc_pkg::ST_ACCEPT, 0, 0});
    add_row(kcc_pkg::FUNC_POP, 0, 0, 1, '{kcc_pkg::ST_REMOVED, 4095, 1});
    add_row(kcc_pkg::FUNC_CLEAR, 0, 0, 1, '{kcc_pkg::ST_ACCEPT, 0, 1});
    add_row(kcc_pkg::FUNC_ADD, 0, 4095, 1, '{kcc_pkg::ST_ACCEPT, 0, 1});
    add_row(kcc_pkg::FUNC_ADD, 1, 2, 0, '0);
    add_row(kcc_pkg::FUNC_ADD, 1, 3, 0, '0);
    add_row(kcc_pkg::FUNC_ADD, 2, 1, 0, '0);
    add_row(kcc_pkg::FUNC_ADD, 2, 3, 0, '0);
    add_row(kcc_pkg::FUNC_ADD, 3, 1, 0, '0);
    add_row(kcc_pkg::FUNC_ADD, 3, 2, 0, '0);
    add_row(kcc_pkg::FUNC_ADD, 2, 0, 1, '{kcc_pkg::ST_REJECT, 0, 1});
    add_row(kcc_pkg::FUNC_ADD, 4095, 0, 0, '0);
    add_row(kcc_pkg::FUNC_BEGIN, 0, 0, 1, '{kcc_pkg::ST_ACCEPT, 0, 1});
    add_row(kcc_pkg::FUNC_SEED, 1, 0, 0, '0);
    add_row(kcc_pkg::FUNC_SEED, 1, 0, 0, '0);
    for (int i = 0; i < 5; i++) add_row(kcc_pkg::FUNC_POP, 0, 0, 0, '0);
    foreach (rows[i]) send_word(rows[i].f, rows[i].n, rows[i].b, rows[i].typed, rows[i].res);

    // random peeling runs, mostly well formed
    count_rand = 1;
    for (int ph = 0; rand_sent < RAND_ITEMS; ph++) begin
      write_reg(kcc_pkg::CFG_CORE_ORDER,
                (ph % 7 == 6) ? $urandom_range(1, 5) : core_opts[ph % 6]);
      write_reg(kcc_pkg::CFG_NODE_COUNT,
                (ph % 5 == 4) ? $urandom_range(3, 4096) : cnt_opts[ph % 6]);
      send_word(kcc_pkg::FUNC_CLEAR, 0, 0);
      lim = node_lim();
      g = (lim < 24) ? lim : $urandom_range(4, 24);
      base = $urandom_range(0, lim - g);
      for (int o = 0; o < g; o++) begin
        nd = $urandom_range(0, 4);
        for (int d = 0; d < nd; d++) begin
          nb = base + $urandom_range(0, g - 1);
          if ($urandom_range(0, 15) == 0) nb = $urandom_range(0, 4095);
          send_word(kcc_pkg::FUNC_ADD, base + o, nb);
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: send_word(kcc_pkg::FUNC_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095));
            1: send_word(kcc_pkg::FUNC_SEED, $urandom_range(0, 4095), 0);
            default: send_word(3'(FUNC_UNDEF_LO + $urandom_range(0, 2)),
                               $urandom_range(0, 4095), $urandom_range(0, 4095));
          endcase
        end
      end
      send_word(kcc_pkg::FUNC_BEGIN, $urandom_range(0, 4095), $urandom_range(0, 4095));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) begin
          send_word(kcc_pkg::FUNC_SEED, $urandom_range(0, 4095), 0);
        end else begin
          send_word(kcc_pkg::FUNC_SEED, base + $urandom_range(0, g - 1),
                    $urandom_range(0, 4095));
        end
      end
      pops = 0;
      while (qn > 0 && pops < 300) begin
        send_word(kcc_pkg::FUNC_POP, $urandom_range(0, 4095), $urandom_range(0, 4095));
        pops++;
      end
      send_word(kcc_pkg::FUNC_POP, 0, 0);
    end

    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered: directed rows with reset, reject and empty cases, %0d random words",
             rand_sent);
    $display("nodes removed: %0d, words rejected: %0d", removals, rejects);
    if (errors == 0) begin
      $display("PASS k_core_collapse_cascade_top");
    end else begin
      $display("FAIL k_core_collapse_cascade_top");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kcc_pkg.sv
rtl/kcc_ram.sv
rtl/k_core_collapse_cascade_top.sv
tb/sv/tb_k_core_collapse_cascade_top.sv
